@@ hdl/gbnms_pkg.sv @@
// shared constants and types for the greedy box suppression block
`timescale 1ns / 1ps
`default_nettype none
package gbnms_pkg;
   localparam int MaxBoxes = 64;
   localparam int CoordBits = 16;
   localparam int ScoreBits = 16;
   localparam int IdxBits = 6;
   localparam int CntBits = 7;
   localparam int AreaBits = 2 * CoordBits + 2;
   localparam logic [15:0] ThreshReset = 16'd29491;

   typedef struct packed {
      logic signed [CoordBits-1:0] x1;
      logic signed [CoordBits-1:0] y1;
      logic signed [CoordBits-1:0] x2;
      logic signed [CoordBits-1:0] y2;
      logic [ScoreBits-1:0]        score;
      logic signed [AreaBits-1:0]  area;
   } box_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic                load;
      logic [IdxBits-1:0]  load_idx;
      logic                clear;
      logic                mark;
      logic [IdxBits-1:0]  mark_idx;
      logic                test;
   } cell_ctl_type;

   typedef enum logic [4:0] {
      ST_LOAD   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_PICK   = 5'b00100,
      ST_TEST   = 5'b01000,
      ST_APPLY  = 5'b10000
   } state_type;
endpackage
`default_nettype wire

@@ hdl/greedy_box_nms_top.sv @@
// greedy box suppression: controller and row of box cells
// Usage: boxes arrive on the req_ channel, one transfer per box, one per cycle
// while loading. The box with req_is_last_box ends the set; req_ready then stays
// low until the last index of the set has gone into the output register.
// Boxes past 64 are dropped and rsp_overflow is set on every index of the set.
// Each round the cells pass the best live box along the chain, one cell per
// cycle, until it has crossed every cell; the pick is marked, then every cell
// tests its box against it in parallel (pick, test and apply states).
// An index is emitted at the scan after its round, once end_of_list is known;
// the next set can load as soon as the last index is presented.
// A stalled rsp_ channel holds the result in the output register and freezes
// the controller at its next scan; nothing is dropped.
// rsp_end_of_list marks the final index of the set.
// Reset clears the box count, done flags and the threshold to 29491.
// csr_ writes set the iou threshold and must only occur while idle.
`timescale 1ns / 1ps
`default_nettype none
module greedy_box_nms_top import gbnms_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [15:0]          csr_overlap_threshold,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic signed [CoordBits-1:0] req_x_left,
   input  wire logic signed [CoordBits-1:0] req_y_top,
   input  wire logic signed [CoordBits-1:0] req_x_right,
   input  wire logic signed [CoordBits-1:0] req_y_bottom,
   input  wire logic [ScoreBits-1:0] req_box_score,
   input  wire logic                 req_is_last_box,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [IdxBits-1:0]        rsp_kept_index,
   output logic                      rsp_end_of_list,
   output logic                      rsp_overflow
);
   state_type state_ff, state_in;
   logic [15:0] thresh_ff;
   logic [CntBits-1:0] count_ff, count_in;
   logic [CntBits-1:0] scnt_ff, scnt_in;
   logic ovf_ff, ovf_in;
   logic [IdxBits-1:0] pick_ff;
   logic held_ff;
   logic [1:0] tcnt_ff;
   cell_ctl_type ctl;
   box_type load_box, pick_box;
   box_type boxes [MaxBoxes];
   logic cf [MaxBoxes+1];
   logic [ScoreBits-1:0] cs [MaxBoxes+1];
   logic [IdxBits-1:0] ci [MaxBoxes+1];
   logic accept, out_free, chain_ok, decide, emit;
   logic signed [CoordBits:0] dx, dy;

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == ST_LOAD);
   assign out_free = !rsp_valid || rsp_ready;
   // chain output is settled once the scan counter has reached MaxBoxes
   assign chain_ok = (scnt_ff == CntBits'(MaxBoxes));
   assign decide = (state_ff == ST_SCAN) && chain_ok && out_free;
   assign emit = decide && held_ff;

   always_comb begin
      dx = {req_x_right[CoordBits-1], req_x_right} - {req_x_left[CoordBits-1], req_x_left};
      dy = {req_y_bottom[CoordBits-1], req_y_bottom} - {req_y_top[CoordBits-1], req_y_top};
      load_box.x1 = req_x_left;
      load_box.y1 = req_y_top;
      load_box.x2 = req_x_right;
      load_box.y2 = req_y_bottom;
      load_box.score = req_box_score;
      load_box.area = AreaBits'(dx * dy);
   end

   assign pick_box = boxes[pick_ff];
   assign cf[0] = 1'b0;
   assign cs[0] = '0;
   assign ci[0] = '0;

   for (genvar g = 0; g < MaxBoxes; g++) begin : g_cell
      gbnms_cell u_cell (
         .clock(clock), .reset(reset), .my_idx(IdxBits'(g)), .ctl(ctl),
         .load_box(load_box), .pick_box(pick_box), .thresh(thresh_ff),
         .valid_slot(CntBits'(g) < count_ff),
         .chain_found_i(cf[g]), .chain_score_i(cs[g]), .chain_idx_i(ci[g]),
         .chain_found_o(cf[g+1]), .chain_score_o(cs[g+1]), .chain_idx_o(ci[g+1]),
         .box_o(boxes[g])
      );
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in = ovf_ff;
      scnt_in = '0;
      ctl = '0;
      ctl.load_idx = count_ff[IdxBits-1:0];
      ctl.mark_idx = ci[MaxBoxes];
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (count_ff < CntBits'(MaxBoxes)) begin
                  ctl.load = 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_is_last_box) state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            scnt_in = chain_ok ? scnt_ff : scnt_ff + 1'b1;
            if (decide) begin
               if (cf[MaxBoxes]) begin
                  ctl.mark = 1'b1;
                  state_in = ST_PICK;
               end else begin
                  // end of set once nothing is live
                  ctl.clear = 1'b1;
                  count_in = '0;
                  ovf_in = 1'b0;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_PICK: state_in = ST_TEST;
         ST_TEST: if (tcnt_ff == 2'd1) state_in = ST_APPLY;
         ST_APPLY: begin
            ctl.test = 1'b1;
            state_in = ST_SCAN;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         scnt_ff <= '0;
         ovf_ff <= 1'b0;
         thresh_ff <= ThreshReset;
         rsp_valid <= 1'b0;
         tcnt_ff <= '0;
         held_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         scnt_ff <= scnt_in;
         ovf_ff <= ovf_in;
         if (csr_we) thresh_ff <= csr_overlap_threshold;
         tcnt_ff <= (state_ff == ST_TEST) ? tcnt_ff + 1'b1 : 2'd0;
         if (emit) rsp_valid <= 1'b1;
         else if (rsp_ready) rsp_valid <= 1'b0;
         if (decide) held_ff <= cf[MaxBoxes];
      end
   end

   // end_of_list is known only after the following scan, so a pending result is
   // held in pick_ff and emitted with its flag one round later
   always_ff @(posedge clock) begin
      if (decide && cf[MaxBoxes]) pick_ff <= ci[MaxBoxes];
      if (emit) begin
         rsp_kept_index <= pick_ff;
         rsp_overflow <= ovf_ff;
         rsp_end_of_list <= !cf[MaxBoxes];
      end
   end
endmodule
`default_nettype wire

@@ hdl/gbnms_cell.sv @@
// one box slot: holds a box, its done flag, and does one iou test against the picked box
`timescale 1ns / 1ps
`default_nettype none
module gbnms_cell import gbnms_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [IdxBits-1:0]  my_idx,
   input  wire cell_ctl_type        ctl,
   input  wire box_type             load_box,
   input  wire box_type             pick_box,
   input  wire logic [15:0]         thresh,
   input  wire logic                valid_slot,
   // max chain: best so far from the lower neighbor
   input  wire logic                chain_found_i,
   input  wire logic [ScoreBits-1:0] chain_score_i,
   input  wire logic [IdxBits-1:0]  chain_idx_i,
   output logic                     chain_found_o,
   output logic [ScoreBits-1:0]     chain_score_o,
   output logic [IdxBits-1:0]       chain_idx_o,
   output box_type                  box_o
);
   box_type box_ff;
   logic live;
   logic done_ff, done_in;
   logic supp_ff, supp_in;
   logic found_ff, found_in;
   logic [ScoreBits-1:0] score_ff, score_in;
   logic [IdxBits-1:0] idx_ff, idx_in;
   logic signed [CoordBits:0] w_s, h_s;
   logic [CoordBits:0] w_u, h_u;
   logic [2*CoordBits+1:0] inter_ff, inter_in;
   logic signed [AreaBits+1:0] uni_ff, uni_in;
   logic [AreaBits+17:0] lhs, rhs;
   logic signed [CoordBits-1:0] mnx, mxx, mny, mxy;

   assign live = valid_slot && !done_ff;
   assign box_o = box_ff;
   assign chain_found_o = found_ff;
   assign chain_score_o = score_ff;
   assign chain_idx_o   = idx_ff;

   // chain compare: strict greater keeps the lowest index on ties
   // one cell per cycle, so the chain settles after a full pass
   always_comb begin
      found_in = chain_found_i;
      score_in = chain_score_i;
      idx_in   = chain_idx_i;
      if (live && (!chain_found_i || box_ff.score > chain_score_i)) begin
         found_in = 1'b1;
         score_in = box_ff.score;
         idx_in   = my_idx;
      end
   end

   always_comb begin
      mnx = (pick_box.x2 < box_ff.x2) ? pick_box.x2 : box_ff.x2;
      mxx = (pick_box.x1 > box_ff.x1) ? pick_box.x1 : box_ff.x1;
      mny = (pick_box.y2 < box_ff.y2) ? pick_box.y2 : box_ff.y2;
      mxy = (pick_box.y1 > box_ff.y1) ? pick_box.y1 : box_ff.y1;
      w_s = {mnx[CoordBits-1], mnx} - {mxx[CoordBits-1], mxx};
      h_s = {mny[CoordBits-1], mny} - {mxy[CoordBits-1], mxy};
      w_u = w_s[CoordBits] ? '0 : w_s;
      h_u = h_s[CoordBits] ? '0 : h_s;
      inter_in = (2*CoordBits+2)'(w_u * h_u);
      uni_in = (AreaBits+2)'(pick_box.area) + (AreaBits+2)'(box_ff.area);
      lhs = {(AreaBits+18-(2*CoordBits+2)-16)'(0), inter_ff, 16'd0};
      rhs = (AreaBits+18)'(thresh * uni_ff[AreaBits:0]);
      supp_in = 1'b0;
      if (uni_ff > 0 && lhs > rhs) supp_in = 1'b1;
   end

   // inter and the partial union are registered first, then the compare into supp_ff
   always_ff @(posedge clock) begin
      if (ctl.load && ctl.load_idx == my_idx) box_ff <= load_box;
      inter_ff <= inter_in;
      uni_ff   <= uni_in - $signed({2'b00, inter_in});
      supp_ff  <= supp_in;
      score_ff <= score_in;
      idx_ff   <= idx_in;
   end

   always_comb begin
      done_in = done_ff;
      if (ctl.mark && ctl.mark_idx == my_idx) done_in = 1'b1;
      if (ctl.test && live && supp_ff) done_in = 1'b1;
      if (ctl.clear) done_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
         found_ff <= found_in;
      end
   end
endmodule
`default_nettype wire

@@ tb/greedy_box_nms_top_tb.sv @@
// testbench for greedy_box_nms_top: directed table then random box sets, checked by a predictor
`timescale 1ns / 1ps
module greedy_box_nms_top_tb;
   import gbnms_pkg::*;

   localparam int CycleLimit = 2000000;

   typedef struct packed {
      logic signed [CoordBits-1:0] x1, y1, x2, y2;
      logic [ScoreBits-1:0] score;
      logic last;
   } box_req_type;

   typedef struct packed {
      logic [IdxBits-1:0] idx;
      logic eol;
      logic ovf;
   } keep_type;

   // directed row: box plus an optional typed-in expectation for a one-box set
   typedef struct {
      box_req_type b;
      logic has_exp;
      keep_type exp;
   } row_type;

   logic clock = 0, reset = 1;
   logic csr_we = 0;
   logic [15:0] csr_overlap_threshold = '0;
   logic req_valid = 0, req_ready;
   logic signed [CoordBits-1:0] req_x_left = '0, req_y_top = '0, req_x_right = '0,
      req_y_bottom = '0;
   logic [ScoreBits-1:0] req_box_score = '0;
   logic req_is_last_box = 0;
   logic rsp_valid, rsp_ready = 0;
   logic [IdxBits-1:0] rsp_kept_index;
   logic rsp_end_of_list, rsp_overflow;

   greedy_box_nms_top dut (
      .clock(clock), .reset(reset), .csr_we(csr_we),
      .csr_overlap_threshold(csr_overlap_threshold),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_x_left(req_x_left), .req_y_top(req_y_top), .req_x_right(req_x_right),
      .req_y_bottom(req_y_bottom), .req_box_score(req_box_score),
      .req_is_last_box(req_is_last_box),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kept_index(rsp_kept_index),
      .rsp_end_of_list(rsp_end_of_list), .rsp_overflow(rsp_overflow));

   initial begin
      forever #6 clock = ~clock;
   end

   // predictor state
   logic [15:0] iou_thresh = ThreshReset;
   box_req_type held [MaxBoxes];
   logic signed [AreaBits-1:0] held_area [MaxBoxes];
   int held_count = 0;
   logic dropped = 0;
   keep_type kept_q [$];
   int errors = 0, boxes_sent = 0, results_seen = 0, overflow_sets = 0;
   longint cycles = 0;
   logic hold_off = 0;

   function automatic logic too_close(int a, int b);
      logic signed [63:0] w, h, inter, uni;
      logic [127:0] lhs, rhs;
      w = ((held[a].x2 < held[b].x2) ? held[a].x2 : held[b].x2)
         - ((held[a].x1 > held[b].x1) ? held[a].x1 : held[b].x1);
      h = ((held[a].y2 < held[b].y2) ? held[a].y2 : held[b].y2)
         - ((held[a].y1 > held[b].y1) ? held[a].y1 : held[b].y1);
      if (w < 0) w = 0;
      if (h < 0) h = 0;
      inter = w * h;
      uni = 64'(held_area[a]) + 64'(held_area[b]) - inter;
      if (uni <= 0) return 0;
      lhs = 128'(inter) << 16;
      rhs = 128'(iou_thresh) * 128'(uni);
      return lhs > rhs;
   endfunction

   task automatic predict_box(box_req_type b);
      logic [MaxBoxes-1:0] done;
      int best;
      keep_type k;
      if (held_count < MaxBoxes) begin
         held[held_count] = b;
         held_area[held_count] = (AreaBits'(b.x2) - AreaBits'(b.x1))
            * (AreaBits'(b.y2) - AreaBits'(b.y1));
         held_count++;
      end else
         dropped = 1;
      if (!b.last) return;
      done = '0;
      if (dropped) overflow_sets++;
      forever begin
         best = -1;
         for (int i = 0; i < held_count; i++)
            if (!done[i] && (best < 0 || held[i].score > held[best].score)) best = i;
         if (best < 0) break;
         done[best] = 1;
         k.idx = IdxBits'(best);
         k.eol = 0;
         k.ovf = dropped;
         kept_q.insert(kept_q.size(), k);
         for (int i = 0; i < held_count; i++)
            if (!done[i] && too_close(best, i)) done[i] = 1;
      end
      kept_q[kept_q.size()-1].eol = 1;
      held_count = 0;
      dropped = 0;
   endtask

   // sampled at the rising edge
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         keep_type e;
         results_seen++;
         if (kept_q.size() == 0) begin
            $error("result with nothing expected: index %0d", rsp_kept_index);
            errors++;
         end else begin
            e = kept_q.pop_front();
            if (e.idx !== rsp_kept_index) begin
               $error("kept_index expected %0d actual %0d", e.idx, rsp_kept_index);
               errors++;
            end
            if (e.eol !== rsp_end_of_list) begin
               $error("end_of_list expected %0d actual %0d", e.eol, rsp_end_of_list);
               errors++;
            end
            if (e.ovf !== rsp_overflow) begin
               $error("overflow expected %0d actual %0d", e.ovf, rsp_overflow);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("** greedy_box_nms_top: FAILED **");
         $finish;
      end
   end

   // receiver: random stalls, long hold-off when asked
   initial begin
      int g;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_ready <= 0;
            @(negedge clock);
         end else begin
            g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
            if ($urandom_range(0, 2) == 0) g = 0;
            rsp_ready <= (g == 0);
            repeat (g > 0 ? g : 1) @(negedge clock);
            if (g > 0) begin
               rsp_ready <= 1;
               @(negedge clock);
            end
         end
      end
   end

   // valid stays up across back-to-back transfers; callers drop it after the last one
   task automatic send_box(box_req_type b, int gap);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_x_left <= b.x1;
      req_y_top <= b.y1;
      req_x_right <= b.x2;
      req_y_bottom <= b.y2;
      req_box_score <= b.score;
      req_is_last_box <= b.last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_box(b);
      boxes_sent++;
      @(negedge clock);
   endtask

   // transfer of a directed row whose result was typed in ahead
   task automatic send_box_raw(box_req_type b);
      req_valid <= 1;
      req_x_left <= b.x1;
      req_y_top <= b.y1;
      req_x_right <= b.x2;
      req_y_bottom <= b.y2;
      req_box_score <= b.score;
      req_is_last_box <= b.last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      boxes_sent++;
      @(negedge clock);
   endtask

   function automatic int rand_gap();
      if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
      if ($urandom_range(0, 1) == 0) return 0;
      return $urandom_range(1, 3);
   endfunction

   task automatic drain_and_set(logic [15:0] t);
      while (kept_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_we <= 1;
      csr_overlap_threshold <= t;
      @(negedge clock);
      csr_we <= 0;
      iou_thresh = t;
   endtask

   function automatic box_req_type rand_box(logic last, int spread);
      box_req_type b;
      int cx, cy;
      if (spread == 0) begin
         b.x1 = CoordBits'($urandom);
         b.y1 = CoordBits'($urandom);
         b.x2 = CoordBits'($urandom);
         b.y2 = CoordBits'($urandom);
      end else begin
         // clustered boxes so that overlaps are common
         cx = $urandom_range(0, 400) - 200;
         cy = $urandom_range(0, 400) - 200;
         b.x1 = CoordBits'(cx);
         b.y1 = CoordBits'(cy);
         b.x2 = CoordBits'(cx + int'($urandom_range(1, spread)));
         b.y2 = CoordBits'(cy + int'($urandom_range(1, spread)));
      end
      b.score = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
      b.last = last;
      return b;
   endfunction

   row_type rows [$];

   function automatic row_type mk(int x1, int y1, int x2, int y2, int s, int l,
                                   int he, int ei);
      row_type r;
      r.b = '{16'(x1), 16'(y1), 16'(x2), 16'(y2), 16'(s), 1'(l)};
      r.has_exp = 1'(he);
      r.exp = '{6'(ei), 1'b1, 1'b0};
      return r;
   endfunction

   initial begin
      int n, spread;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // one-box sets give index 0 at a glance
      rows.insert(rows.size(), mk(-32768, -32768, 32767, 32767, 65535, 1, 1, 0));
      rows.insert(rows.size(), mk(32767, 32767, -32768, -32768, 0, 1, 1, 0));
      rows.insert(rows.size(), mk(0, 0, 0, 0, 0, 1, 1, 0));
      // identical boxes: second suppressed; tie goes to lowest index
      rows.insert(rows.size(), mk(0, 0, 16, 16, 100, 0, 0, 0));
      rows.insert(rows.size(), mk(0, 0, 16, 16, 100, 1, 0, 0));
      // disjoint boxes, rising scores
      rows.insert(rows.size(), mk(0, 0, 16, 16, 1, 0, 0, 0));
      rows.insert(rows.size(), mk(100, 100, 116, 116, 2, 0, 0, 0));
      rows.insert(rows.size(), mk(-200, -200, -100, -100, 65535, 1, 0, 0));
      // inverted boxes and degenerate union
      rows.insert(rows.size(), mk(16, 16, 0, 0, 50, 0, 0, 0));
      rows.insert(rows.size(), mk(16, 16, 0, 0, 60, 0, 0, 0));
      rows.insert(rows.size(), mk(5, 5, 5, 5, 70, 1, 0, 0));
      // partial overlap near threshold, extreme span overlap
      rows.insert(rows.size(), mk(0, 0, 100, 100, 9, 0, 0, 0));
      rows.insert(rows.size(), mk(20, 0, 120, 100, 8, 0, 0, 0));
      rows.insert(rows.size(), mk(-32768, -32768, 32767, 32767, 7, 0, 0, 0));
      rows.insert(rows.size(), mk(-32767, -32768, 32767, 32767, 6, 1, 0, 0));
      foreach (rows[i]) begin
         // typed-in rows bypass the predictor for the final result
         if (rows[i].has_exp) begin
            predict_box(rows[i].b);
            void'(kept_q.pop_back());
            kept_q.insert(kept_q.size(), rows[i].exp);
            send_box_raw(rows[i].b);
         end else
            send_box(rows[i].b, rand_gap());
      end
      req_valid <= 0;

      // overflow set: 66 boxes, last two dropped, with long rsp hold-off
      // while a second set waits at the input
      drain_and_set(16'd0);
      fork
         begin
            hold_off = 1;
            repeat (400) @(negedge clock);
            hold_off = 0;
         end
         begin
            for (int i = 0; i < 66; i++) send_box(rand_box(i == 65, 64), 0);
            for (int i = 0; i < 5; i++) send_box(rand_box(i == 4, 64), 0);
            req_valid <= 0;
         end
      join

      // random sets across thresholds, extremes included
      n = 0;
      while (boxes_sent < 395) begin
         case (n % 4)
            0: drain_and_set(16'hFFFF);
            1: drain_and_set(16'($urandom));
            2: drain_and_set(16'd1);
            default: drain_and_set(ThreshReset);
         endcase
         for (int s = 0; s < 3; s++) begin
            int len;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 10);
            spread = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 300);
            for (int i = 0; i < len; i++) send_box(rand_box(i == len - 1, spread), rand_gap());
         end
         req_valid <= 0;
         n++;
      end

      while (kept_q.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      $display("sent %0d boxes, checked %0d kept indexes, %0d overflow sets",
         boxes_sent, results_seen, overflow_sets);
      $display("thresholds covered: 0, 1, reset value, 65535 and random values");
      if (errors == 0)
         $display("** greedy_box_nms_top: PASSED **");
      else
         $display("** greedy_box_nms_top: FAILED **");
      $finish;
   end
endmodule
